@@ sv/q2e_pkg.sv @@
// ============================================================================
// q2e_pkg: shared types, constants and arithmetic steps for quaternion_to_euler
// Widths of the angle datapath, CORDIC/normalize step helpers and payload structs.
// ============================================================================
package q2e_pkg;

    // output angle width
    localparam int ANGLE_WIDTH  = 16;

    // internal datapath widths
    localparam int VEC_W        = 44;   // CORDIC x/y, covers 2^40 * gain
    localparam int ANG_W        = 34;   // CORDIC angle, rad * 2^30
    localparam int ANG_LO_W     = ANG_W / 2;
    localparam int SQ_W         = 64;   // isqrt radicand/root

    localparam int ANG_BITS     = 30;
    localparam int NORM_BITS    = 39;
    localparam int CORDIC_STEPS = 31;
    localparam int ISQRT_STEPS  = 32;
    localparam int NORM_STEPS   = 6;
    localparam int STEP_W       = $clog2(ISQRT_STEPS);
    localparam int SHIFT_W      = NORM_STEPS;

    localparam int RAD_SH       = ANG_BITS - (ANGLE_WIDTH - 3);
    localparam int DEG_SH       = 24 + ANG_BITS - (ANGLE_WIDTH - 9);

    localparam logic signed [ANG_W-1:0] HALF_PI  = ANG_W'(64'sd1686629713);
    localparam logic signed [30:0]      RAD2DEG  = 31'sd961263669;

    localparam logic signed [ANG_W-1:0] ATAN_TAB [0:10] = '{
        ANG_W'(64'sd843314856), ANG_W'(64'sd497837829), ANG_W'(64'sd263043836),
        ANG_W'(64'sd133525158), ANG_W'(64'sd67021686),  ANG_W'(64'sd33543515),
        ANG_W'(64'sd16775850),  ANG_W'(64'sd8388437),   ANG_W'(64'sd4194282),
        ANG_W'(64'sd2097149),   ANG_W'(64'sd1048575)
    };

    // one vector on its way through normalize and CORDIC
    typedef struct packed {
        logic                      hold;   // angle already known, skip rotation
        logic signed [VEC_W-1:0]   x;
        logic signed [VEC_W-1:0]   y;
        logic signed [ANG_W-1:0]   z;
    } t_vec;

    typedef struct packed {
        logic zero_norm;
        t_vec yaw;
        t_vec pitch;
        t_vec roll;
    } t_job;

    typedef struct packed {
        logic [SQ_W-1:0] v;
        logic [SQ_W-1:0] r;
        t_job            job;
    } t_sq;

    function automatic logic signed [ANG_W-1:0] atan_step(logic [STEP_W-1:0] i);
        if (i <= STEP_W'(10)) begin
            return ATAN_TAB[i[3:0]];
        end
        return ANG_W'(64'sd1) <<< (ANG_BITS - int'(i));
    endfunction

    // shift left by sh when max(|x|,|y|) < 2^(NORM_BITS+1-sh)
    function automatic t_vec norm_step(t_vec v, logic [SHIFT_W-1:0] sh);
        t_vec             r;
        logic [VEC_W-1:0] ax;
        logic [VEC_W-1:0] ay;
        logic [VEC_W-1:0] lim;
        r   = v;
        ax  = v.x[VEC_W-1] ? VEC_W'(-v.x) : VEC_W'(v.x);
        ay  = v.y[VEC_W-1] ? VEC_W'(-v.y) : VEC_W'(v.y);
        lim = VEC_W'(1) << (NORM_BITS + 1 - int'(sh));
        if (ax < lim && ay < lim) begin
            r.x = v.x <<< sh;
            r.y = v.y <<< sh;
        end
        return r;
    endfunction

    // fold the left half plane into the right one
    function automatic t_vec prerotate(t_vec v);
        t_vec r;
        r = v;
        if (!v.hold && v.x[VEC_W-1]) begin
            if (!v.y[VEC_W-1]) begin
                r.x = v.y;
                r.y = -v.x;
                r.z = HALF_PI;
            end else begin
                r.x = -v.y;
                r.y = v.x;
                r.z = -HALF_PI;
            end
        end
        return r;
    endfunction

    function automatic t_vec cordic_rot(t_vec v, logic [STEP_W-1:0] i);
        t_vec                    r;
        logic signed [VEC_W-1:0] dx;
        logic signed [VEC_W-1:0] dy;
        r  = v;
        dx = v.y >>> i;
        dy = v.x >>> i;
        if (!v.hold) begin
            if (v.y > 0) begin
                r.x = v.x + dx;
                r.y = v.y - dy;
                r.z = v.z + atan_step(i);
            end else begin
                r.x = v.x - dx;
                r.y = v.y + dy;
                r.z = v.z - atan_step(i);
            end
        end
        return r;
    endfunction

endpackage

@@ sv/q2e_isqrt_cell.sv @@
// ============================================================================
// q2e_isqrt_cell: one digit step of the integer square root
// Takes one radicand bit pair per cell; carries the angle job alongside.
// ============================================================================
module q2e_isqrt_cell (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [q2e_pkg::STEP_W-1:0]  i_step,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  q2e_pkg::t_sq                i_data,
    output logic                        o_valid,
    input  logic                        i_ready,
    output q2e_pkg::t_sq                o_data
);

    logic                        r_valid;
    q2e_pkg::t_sq                r_data;
    q2e_pkg::t_sq                n_data;
    logic [q2e_pkg::SQ_W-1:0]    bitv;
    logic [q2e_pkg::SQ_W-1:0]    trial;

    always_comb begin
        bitv   = q2e_pkg::SQ_W'(1) << (6'd62 - {i_step, 1'b0});
        trial  = i_data.r + bitv;
        n_data = i_data;
        if (i_data.v >= trial) begin
            n_data.v = i_data.v - trial;
            n_data.r = (i_data.r >> 1) + bitv;
        end else begin
            n_data.r = i_data.r >> 1;
        end
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

@@ sv/q2e_norm_cell.sv @@
// ============================================================================
// q2e_norm_cell: one binary step of the vector normalize shift
// Shifts yaw, pitch and roll vectors left by a fixed power of two if small.
// ============================================================================
module q2e_norm_cell (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic [q2e_pkg::SHIFT_W-1:0]  i_shift,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  q2e_pkg::t_job                i_data,
    output logic                         o_valid,
    input  logic                         i_ready,
    output q2e_pkg::t_job                o_data
);

    logic           r_valid;
    q2e_pkg::t_job  r_data;
    q2e_pkg::t_job  n_data;

    always_comb begin
        n_data       = i_data;
        n_data.yaw   = q2e_pkg::norm_step(i_data.yaw, i_shift);
        n_data.pitch = q2e_pkg::norm_step(i_data.pitch, i_shift);
        n_data.roll  = q2e_pkg::norm_step(i_data.roll, i_shift);
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

@@ sv/q2e_cordic_cell.sv @@
// ============================================================================
// q2e_cordic_cell: one vectoring micro-rotation
// Rotates yaw, pitch and roll vectors toward the x axis by one fixed step.
// ============================================================================
module q2e_cordic_cell (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [q2e_pkg::STEP_W-1:0]  i_step,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  q2e_pkg::t_job               i_data,
    output logic                        o_valid,
    input  logic                        i_ready,
    output q2e_pkg::t_job               o_data
);

    logic           r_valid;
    q2e_pkg::t_job  r_data;
    q2e_pkg::t_job  n_data;

    always_comb begin
        n_data       = i_data;
        n_data.yaw   = q2e_pkg::cordic_rot(i_data.yaw, i_step);
        n_data.pitch = q2e_pkg::cordic_rot(i_data.pitch, i_step);
        n_data.roll  = q2e_pkg::cordic_rot(i_data.roll, i_step);
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

@@ sv/quaternion_to_euler.sv @@
// ============================================================================
// quaternion_to_euler: Q2.14 quaternion to Z-Y-X Euler angles
// Yaw and roll by CORDIC atan2, pitch by asin through isqrt and CORDIC.
// ============================================================================
//
//  channel   | direction | transfer moves
//  ----------+-----------+--------------------------------------------------
//  s_axis    | in        | quat_real, quat_i, quat_j, quat_k
//  m_axis    | out       | yaw, pitch, roll angles; tuser = zero_norm
//  cfg       | in        | output_in_degrees (1 = degrees Q9.7, 0 = rad Q3.13)
//
//  One quaternion per cycle sustained while m_axis is not stalled; the pipeline
//  holds five front stages, 32 isqrt cells, 6 normalize cells, one quadrant
//  stage, 31 CORDIC cells and two output stages. The isqrt chain, needed only
//  for pitch, carries yaw and roll too. Reset clears every valid bit and sets degrees mode.
//  Each stage holds its data only while the stage after it is full and stalled,
//  so bubbles close up and input is taken while a result waits at the output.
//
module quaternion_to_euler (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // s_axis tdata: quat_real[15:0], quat_i[31:16], quat_j[47:32], quat_k[63:48]
    input  logic                                 i_s_axis_tvalid,
    output logic                                 o_s_axis_tready,
    input  logic [63:0]                          i_s_axis_tdata,
    // m_axis tdata: yaw_angle, pitch_angle, roll_angle (ANGLE_WIDTH each, low first)
    output logic                                 o_m_axis_tvalid,
    input  logic                                 i_m_axis_tready,
    output logic [((3*q2e_pkg::ANGLE_WIDTH+7)/8)*8-1:0] o_m_axis_tdata,
    // m_axis tuser: zero_norm[0]
    output logic [0:0]                           o_m_axis_tuser,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [0:0]                           i_cfg_data
);

    localparam int AW    = q2e_pkg::ANGLE_WIDTH;
    localparam int VW    = q2e_pkg::VEC_W;
    localparam int ZW    = q2e_pkg::ANG_W;
    localparam int ZL    = q2e_pkg::ANG_LO_W;
    localparam int OUT_W = ((3*AW+7)/8)*8;

    localparam logic signed [63:0] AMAX     = (64'sd1 <<< (AW-1)) - 64'sd1;
    localparam logic signed [63:0] AMIN     = -AMAX - 64'sd1;
    localparam logic signed [63:0] RAD_HALF = 64'sd1 <<< (q2e_pkg::RAD_SH-1);
    localparam logic signed [63:0] DEG_HALF = 64'sd1 <<< (q2e_pkg::DEG_SH-1);

    typedef struct packed {
        logic signed [31:0] sr, si, sj, sk;
        logic signed [31:0] pij, pkr, pjk, pir, pik, pjr;
    } t_prod;

    typedef struct packed {
        logic signed [33:0] y_yaw, x_yaw, y_roll, x_roll, m, n;
    } t_sums;

    typedef struct packed {
        q2e_pkg::t_job job;
        logic [30:0]   n2;
        logic [30:0]   am2;
    } t_scale;

    typedef struct packed {
        q2e_pkg::t_job job;
        logic [61:0]   nn;
        logic [61:0]   mm;
    } t_sqr;

    typedef struct packed {
        logic signed [ZW-1:0] z;
        logic signed [47:0]   ph;
        logic signed [48:0]   pl;
    } t_deg;

    typedef struct packed {
        logic zero_norm;
        t_deg yaw;
        t_deg pitch;
        t_deg roll;
    } t_conv;

    // ---------------------------------------------------------------- config
    logic r_deg;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_deg <= 1'b1;
        end else if (i_cfg_valid) begin
            r_deg <= i_cfg_data[0];
        end
    end

    // ---------------------------------------------------------------- handshake
    logic r1_valid, r2_valid, r3_valid, r4_valid, r5_valid;
    logic r6_valid, r7_valid, r8_valid;
    logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy6, rdy7, rdy8;

    logic          sq_v   [0:q2e_pkg::ISQRT_STEPS];
    logic          sq_rdy [0:q2e_pkg::ISQRT_STEPS];
    q2e_pkg::t_sq  sq_d   [0:q2e_pkg::ISQRT_STEPS];
    logic          nm_v   [0:q2e_pkg::NORM_STEPS];
    logic          nm_rdy [0:q2e_pkg::NORM_STEPS];
    q2e_pkg::t_job nm_d   [0:q2e_pkg::NORM_STEPS];
    logic          cd_v   [0:q2e_pkg::CORDIC_STEPS];
    logic          cd_rdy [0:q2e_pkg::CORDIC_STEPS];
    q2e_pkg::t_job cd_d   [0:q2e_pkg::CORDIC_STEPS];

    // a stage takes new data when empty or when its successor moves
    assign rdy1 = !r1_valid || rdy2;
    assign rdy2 = !r2_valid || rdy3;
    assign rdy3 = !r3_valid || rdy4;
    assign rdy4 = !r4_valid || rdy5;
    assign rdy5 = !r5_valid || sq_rdy[0];
    assign rdy6 = !r6_valid || cd_rdy[0];
    assign rdy7 = !r7_valid || rdy8;
    assign rdy8 = !r8_valid || i_m_axis_tready;

    assign o_s_axis_tready = rdy1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
            r4_valid <= 1'b0;
            r5_valid <= 1'b0;
            r6_valid <= 1'b0;
            r7_valid <= 1'b0;
            r8_valid <= 1'b0;
        end else begin
            if (rdy1) r1_valid <= i_s_axis_tvalid;
            if (rdy2) r2_valid <= r1_valid;
            if (rdy3) r3_valid <= r2_valid;
            if (rdy4) r4_valid <= r3_valid;
            if (rdy5) r5_valid <= r4_valid;
            if (rdy6) r6_valid <= nm_v[q2e_pkg::NORM_STEPS];
            if (rdy7) r7_valid <= cd_v[q2e_pkg::CORDIC_STEPS];
            if (rdy8) r8_valid <= r7_valid;
        end
    end

    // ---------------------------------------------------------------- stage 1: products
    logic signed [15:0] qr, qi, qj, qk;
    t_prod r1, n1;

    assign qr = i_s_axis_tdata[15:0];
    assign qi = i_s_axis_tdata[31:16];
    assign qj = i_s_axis_tdata[47:32];
    assign qk = i_s_axis_tdata[63:48];

    always_comb begin
        n1.sr  = qr * qr;
        n1.si  = qi * qi;
        n1.sj  = qj * qj;
        n1.sk  = qk * qk;
        n1.pij = qi * qj;
        n1.pkr = qk * qr;
        n1.pjk = qj * qk;
        n1.pir = qi * qr;
        n1.pik = qi * qk;
        n1.pjr = qj * qr;
    end

    always_ff @(posedge i_clk) begin
        if (rdy1 && i_s_axis_tvalid) r1 <= n1;
    end

    // ---------------------------------------------------------------- stage 2: sums
    t_sums r2, n2;

    always_comb begin
        n2.y_yaw  = (34'(r1.pij) + 34'(r1.pkr)) <<< 1;
        n2.x_yaw  = 34'(r1.si) - 34'(r1.sj) - 34'(r1.sk) + 34'(r1.sr);
        n2.y_roll = (34'(r1.pjk) + 34'(r1.pir)) <<< 1;
        n2.x_roll = 34'(r1.sk) + 34'(r1.sr) - 34'(r1.si) - 34'(r1.sj);
        n2.m      = (34'(r1.pjr) - 34'(r1.pik)) <<< 1;
        n2.n      = 34'(r1.si) + 34'(r1.sj) + 34'(r1.sk) + 34'(r1.sr);
    end

    always_ff @(posedge i_clk) begin
        if (rdy2 && r1_valid) r2 <= n2;
    end

    // ---------------------------------------------------------------- stage 3: scale, flags
    t_scale r3, n3;
    logic               big, zero_n, sat;
    logic signed [33:0] m2, am;
    logic [33:0]        nsc;

    always_comb begin
        zero_n = (r2.n == 34'sd0);
        // norm at or above 2^31: drop two bits from numerator and norm
        big    = (r2.n[33:31] != 3'b000);
        nsc    = big ? 34'(r2.n >>> 2) : 34'(r2.n);
        m2     = big ? (r2.m >>> 2) : r2.m;
        am     = m2[33] ? -m2 : m2;
        sat    = (am >= signed'(nsc));

        n3.n2  = nsc[30:0];
        n3.am2 = am[30:0];

        n3.job.zero_norm = zero_n;

        n3.job.yaw.x    = VW'(r2.x_yaw);
        n3.job.yaw.y    = VW'(r2.y_yaw);
        n3.job.yaw.z    = '0;
        n3.job.yaw.hold = (r2.x_yaw == 34'sd0) && (r2.y_yaw == 34'sd0);

        n3.job.roll.x    = VW'(r2.x_roll);
        n3.job.roll.y    = VW'(r2.y_roll);
        n3.job.roll.z    = '0;
        n3.job.roll.hold = (r2.x_roll == 34'sd0) && (r2.y_roll == 34'sd0);

        // pitch x arrives from the isqrt chain
        n3.job.pitch.x    = '0;
        n3.job.pitch.y    = VW'(m2);
        n3.job.pitch.hold = zero_n || sat;
        if (zero_n || !sat) begin
            n3.job.pitch.z = '0;
        end else if (m2 > 0) begin
            n3.job.pitch.z = q2e_pkg::HALF_PI;
        end else begin
            n3.job.pitch.z = -q2e_pkg::HALF_PI;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy3 && r2_valid) r3 <= n3;
    end

    // ---------------------------------------------------------------- stage 4: n^2, m^2
    t_sqr r4, n4;

    always_comb begin
        n4.job = r3.job;
        n4.nn  = 62'(r3.n2) * 62'(r3.n2);
        n4.mm  = 62'(r3.am2) * 62'(r3.am2);
    end

    always_ff @(posedge i_clk) begin
        if (rdy4 && r3_valid) r4 <= n4;
    end

    // ---------------------------------------------------------------- stage 5: radicand
    q2e_pkg::t_sq r5, n5;

    always_comb begin
        n5.v   = q2e_pkg::SQ_W'(r4.nn - r4.mm);
        n5.r   = '0;
        n5.job = r4.job;
    end

    always_ff @(posedge i_clk) begin
        if (rdy5 && r4_valid) r5 <= n5;
    end

    // ---------------------------------------------------------------- isqrt chain
    assign sq_v[0] = r5_valid;
    assign sq_d[0] = r5;

    for (genvar g = 0; g < q2e_pkg::ISQRT_STEPS; g++) begin : g_isqrt
        q2e_isqrt_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_step  (q2e_pkg::STEP_W'(g)),
            .i_valid (sq_v[g]),
            .o_ready (sq_rdy[g]),
            .i_data  (sq_d[g]),
            .o_valid (sq_v[g+1]),
            .i_ready (sq_rdy[g+1]),
            .o_data  (sq_d[g+1])
        );
    end

    // ---------------------------------------------------------------- normalize chain
    assign sq_rdy[q2e_pkg::ISQRT_STEPS] = nm_rdy[0];
    assign nm_v[0] = sq_v[q2e_pkg::ISQRT_STEPS];

    always_comb begin
        nm_d[0]         = sq_d[q2e_pkg::ISQRT_STEPS].job;
        nm_d[0].pitch.x = VW'(sq_d[q2e_pkg::ISQRT_STEPS].r);
    end

    for (genvar g = 0; g < q2e_pkg::NORM_STEPS; g++) begin : g_norm
        q2e_norm_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_shift (q2e_pkg::SHIFT_W'(1 << (q2e_pkg::NORM_STEPS - 1 - g))),
            .i_valid (nm_v[g]),
            .o_ready (nm_rdy[g]),
            .i_data  (nm_d[g]),
            .o_valid (nm_v[g+1]),
            .i_ready (nm_rdy[g+1]),
            .o_data  (nm_d[g+1])
        );
    end

    assign nm_rdy[q2e_pkg::NORM_STEPS] = rdy6;

    // ---------------------------------------------------------------- stage 6: quadrant
    q2e_pkg::t_job r6, n6;

    always_comb begin
        n6       = nm_d[q2e_pkg::NORM_STEPS];
        n6.yaw   = q2e_pkg::prerotate(nm_d[q2e_pkg::NORM_STEPS].yaw);
        n6.pitch = q2e_pkg::prerotate(nm_d[q2e_pkg::NORM_STEPS].pitch);
        n6.roll  = q2e_pkg::prerotate(nm_d[q2e_pkg::NORM_STEPS].roll);
    end

    always_ff @(posedge i_clk) begin
        if (rdy6 && nm_v[q2e_pkg::NORM_STEPS]) r6 <= n6;
    end

    // ---------------------------------------------------------------- CORDIC chain
    assign cd_v[0] = r6_valid;
    assign cd_d[0] = r6;

    for (genvar g = 0; g < q2e_pkg::CORDIC_STEPS; g++) begin : g_cordic
        q2e_cordic_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_step  (q2e_pkg::STEP_W'(g)),
            .i_valid (cd_v[g]),
            .o_ready (cd_rdy[g]),
            .i_data  (cd_d[g]),
            .o_valid (cd_v[g+1]),
            .i_ready (cd_rdy[g+1]),
            .o_data  (cd_d[g+1])
        );
    end

    assign cd_rdy[q2e_pkg::CORDIC_STEPS] = rdy7;

    // ---------------------------------------------------------------- stage 7: degree products
    t_conv r7, n7;

    function automatic t_deg deg_split(logic signed [ZW-1:0] z);
        t_deg                   d;
        logic signed [ZW-ZL-1:0] zh;
        logic signed [ZL:0]      zl;
        zh   = z[ZW-1:ZL];
        zl   = {1'b0, z[ZL-1:0]};
        d.z  = z;
        d.ph = 48'(zh * q2e_pkg::RAD2DEG);
        d.pl = 49'(zl * q2e_pkg::RAD2DEG);
        return d;
    endfunction

    always_comb begin
        n7.zero_norm = cd_d[q2e_pkg::CORDIC_STEPS].zero_norm;
        n7.yaw       = deg_split(cd_d[q2e_pkg::CORDIC_STEPS].yaw.z);
        n7.pitch     = deg_split(cd_d[q2e_pkg::CORDIC_STEPS].pitch.z);
        n7.roll      = deg_split(cd_d[q2e_pkg::CORDIC_STEPS].roll.z);
    end

    always_ff @(posedge i_clk) begin
        if (rdy7 && cd_v[q2e_pkg::CORDIC_STEPS]) r7 <= n7;
    end

    // ---------------------------------------------------------------- stage 8: round, saturate
    logic signed [AW-1:0] r8_yaw, r8_pitch, r8_roll;
    logic signed [AW-1:0] n8_yaw, n8_pitch, n8_roll;
    logic                 r8_zero;

    // round half up, then clamp to the signed angle range
    function automatic logic signed [AW-1:0] to_angle(t_deg d, logic deg);
        logic signed [63:0] v;
        if (deg) begin
            v = ((64'(d.ph) <<< ZL) + 64'(d.pl) + DEG_HALF) >>> q2e_pkg::DEG_SH;
        end else begin
            v = (64'(d.z) + RAD_HALF) >>> q2e_pkg::RAD_SH;
        end
        if (v > AMAX) v = AMAX;
        if (v < AMIN) v = AMIN;
        return v[AW-1:0];
    endfunction

    always_comb begin
        n8_yaw   = to_angle(r7.yaw, r_deg);
        n8_roll  = to_angle(r7.roll, r_deg);
        n8_pitch = r7.zero_norm ? '0 : to_angle(r7.pitch, r_deg);
    end

    always_ff @(posedge i_clk) begin
        if (rdy8 && r7_valid) begin
            r8_yaw   <= n8_yaw;
            r8_pitch <= n8_pitch;
            r8_roll  <= n8_roll;
            r8_zero  <= r7.zero_norm;
        end
    end

    assign o_m_axis_tvalid = r8_valid;
    assign o_m_axis_tdata  = OUT_W'({r8_roll, r8_pitch, r8_yaw});
    assign o_m_axis_tuser  = r8_zero;

    // ---------------------------------------------------------------- checks
    // an accepted quaternion lands in the product stage
    a_accept_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready |=> r1_valid)
        else $error("accepted item not captured");

    // zero norm forces pitch to zero at the output
    a_zero_pitch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r8_valid && r8_zero |-> r8_pitch == '0)
        else $error("pitch not cleared on zero norm");

    // after quadrant folding every live pitch vector points into the right half plane
    a_right_half: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r6_valid && !r6.pitch.hold |-> !r6.pitch.x[VW-1])
        else $error("pitch vector left of y axis");

    // the isqrt root fits in 31 bits for every live pitch
    a_root_width: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        sq_v[q2e_pkg::ISQRT_STEPS] && !sq_d[q2e_pkg::ISQRT_STEPS].job.pitch.hold
        |-> sq_d[q2e_pkg::ISQRT_STEPS].r[q2e_pkg::SQ_W-1:31] == '0)
        else $error("isqrt root out of range");

endmodule

@@ dv/tb_top.sv @@
// ============================================================================
// tb_top: stream-level testbench for quaternion_to_euler
// Sends directed and random quaternions through the input stream and predicts
// yaw, pitch, roll and the zero-norm flag with a bit-exact CORDIC model.
// Results are compared in order, under both angle modes and under varied idling.
// ============================================================================
`timescale 1ns / 1ps

module tb_top;

    localparam int  ANGLE_WIDTH  = q2e_pkg::ANGLE_WIDTH;
    localparam int  NORM_BITS    = q2e_pkg::NORM_BITS;
    localparam int  CORDIC_STEPS = q2e_pkg::CORDIC_STEPS;
    localparam int  OUT_W     = ((3*ANGLE_WIDTH+7)/8)*8;
    localparam int  LAT_WAIT  = 100;      // exceeds the pipeline depth
    localparam int  DOG_LIMIT = 5000;     // cycles without any transfer
    localparam longint HALF_PI_Q30 = 64'sd1686629713;
    localparam longint RAD2DEG_Q24 = 64'sd961263669;
    localparam longint ATAN_Q30 [0:10] = '{
        843314856, 497837829, 263043836, 133525158, 67021686,
        33543515, 16775850, 8388437, 4194282, 2097149, 1048575
    };

    typedef struct packed {
        logic [ANGLE_WIDTH-1:0] yaw;
        logic [ANGLE_WIDTH-1:0] pitch;
        logic [ANGLE_WIDTH-1:0] roll;
        logic                   zero_norm;
    } t_angles;

    // Bit-exact angle predictor plus in-order store of expected angles.
    class euler_scoreboard;
        t_angles pending_angles[$];
        int      mismatches = 0;

        function longint rot_step(int i);
            if (i <= 10) begin
                return ATAN_Q30[i];
            end
            return longint'(1) <<< (30 - i);
        endfunction

        // atan2 in radians * 2^30
        function longint atan2_q30(longint y, longint x);
            longint ax, ay, mx, z, t, dx, dy;
            int     s;
            if (x == 0 && y == 0) begin
                return 0;
            end
            ax = x < 0 ? -x : x;
            ay = y < 0 ? -y : y;
            mx = ax > ay ? ax : ay;
            s  = 0;
            z  = 0;
            while (mx < (longint'(1) <<< NORM_BITS)) begin
                mx = mx <<< 1;
                s++;
            end
            x = x <<< s;
            y = y <<< s;
            // fold left half plane
            if (x < 0) begin
                if (y >= 0) begin
                    t = x; x = y; y = -t; z = HALF_PI_Q30;
                end else begin
                    t = x; x = -y; y = t; z = -HALF_PI_Q30;
                end
            end
            for (int i = 0; i < CORDIC_STEPS; i++) begin
                dx = y >>> i;
                dy = x >>> i;
                if (y > 0) begin
                    x += dx; y -= dy; z += rot_step(i);
                end else begin
                    x -= dx; y += dy; z -= rot_step(i);
                end
            end
            return z;
        endfunction

        function longint unsigned int_sqrt(longint unsigned v);
            longint unsigned r, b;
            r = 0;
            b = 64'd1 << 62;
            while (b > v) b >>= 2;
            while (b != 0) begin
                if (v >= r + b) begin
                    v -= r + b;
                    r = (r >> 1) + b;
                end else begin
                    r >>= 1;
                end
                b >>= 2;
            end
            return r;
        endfunction

        // radians*2^30 to output format, round half up, saturate
        function logic [ANGLE_WIDTH-1:0] scale_angle(longint z, bit deg);
            longint v, hi;
            int     sh;
            if (deg) begin
                sh = 24 + 30 - (ANGLE_WIDTH - 9);
                v  = (z * RAD2DEG_Q24 + (longint'(1) <<< (sh - 1))) >>> sh;
            end else begin
                sh = 30 - (ANGLE_WIDTH - 3);
                v  = (z + (longint'(1) <<< (sh - 1))) >>> sh;
            end
            hi = (longint'(1) <<< (ANGLE_WIDTH - 1)) - 1;
            if (v > hi) v = hi;
            if (v < -hi - 1) v = -hi - 1;
            return v[ANGLE_WIDTH-1:0];
        endfunction

        function void note_quat(logic [63:0] d, bit deg);
            longint  qr, qi, qj, qk, sr, si, sj, sk, m, n, am, pz;
            t_angles e;
            qr = longint'($signed(d[15:0]));
            qi = longint'($signed(d[31:16]));
            qj = longint'($signed(d[47:32]));
            qk = longint'($signed(d[63:48]));
            sr = qr*qr; si = qi*qi; sj = qj*qj; sk = qk*qk;
            m  = -2 * (qi*qk - qj*qr);
            n  = si + sj + sk + sr;
            pz = 0;
            e.yaw  = scale_angle(atan2_q30(2*(qi*qj + qk*qr), si - sj - sk + sr), deg);
            e.roll = scale_angle(atan2_q30(2*(qj*qk + qi*qr), -si - sj + sk + sr), deg);
            e.zero_norm = (n == 0);
            if (n != 0) begin
                while (n >= (longint'(1) <<< 31)) begin
                    n = n >>> 2;
                    m = m >>> 2;
                end
                am = m < 0 ? -m : m;
                if (am >= n) begin
                    pz = m > 0 ? HALF_PI_Q30 : -HALF_PI_Q30;
                end else begin
                    pz = atan2_q30(m, longint'(int_sqrt(n*n - m*m)));
                end
            end
            e.pitch = e.zero_norm ? '0 : scale_angle(pz, deg);
            pending_angles.push_back(e);
        endfunction

        function void check_angles(logic [OUT_W-1:0] data, logic zn);
            t_angles e, a;
            a.yaw       = data[ANGLE_WIDTH-1:0];
            a.pitch     = data[2*ANGLE_WIDTH-1:ANGLE_WIDTH];
            a.roll      = data[3*ANGLE_WIDTH-1:2*ANGLE_WIDTH];
            a.zero_norm = zn;
            if (pending_angles.size() == 0) begin
                $display("%0t: unexpected result yaw=%h pitch=%h roll=%h zn=%b",
                         $time, a.yaw, a.pitch, a.roll, a.zero_norm);
                mismatches++;
                return;
            end
            e = pending_angles.pop_front();
            if (a.yaw !== e.yaw) begin
                $display("%0t: yaw exp %h got %h", $time, e.yaw, a.yaw);
                mismatches++;
            end
            if (a.pitch !== e.pitch) begin
                $display("%0t: pitch exp %h got %h", $time, e.pitch, a.pitch);
                mismatches++;
            end
            if (a.roll !== e.roll) begin
                $display("%0t: roll exp %h got %h", $time, e.roll, a.roll);
                mismatches++;
            end
            if (a.zero_norm !== e.zero_norm) begin
                $display("%0t: zero_norm exp %b got %b", $time, e.zero_norm, a.zero_norm);
                mismatches++;
            end
        endfunction
    endclass

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             i_s_axis_tvalid = 1'b0;
    logic             o_s_axis_tready;
    logic [63:0]      i_s_axis_tdata = '0;
    logic             o_m_axis_tvalid;
    logic             i_m_axis_tready = 1'b0;
    logic [OUT_W-1:0] o_m_axis_tdata;
    logic [0:0]       o_m_axis_tuser;
    logic             i_cfg_valid = 1'b0;
    logic             o_cfg_ready;
    logic [0:0]       i_cfg_data = '0;

    euler_scoreboard sb = new();
    bit deg_mode  = 1'b1;     // mirrors the register, reset gives degrees
    int send_pct  = 0;        // sender idle cycles per hundred
    int sink_pct  = 0;        // receiver stall cycles per hundred
    int idle_cycles = 0;

    quaternion_to_euler dut (.*);

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // Track every transfer: note inputs, check results, follow the mode.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) begin
                deg_mode = i_cfg_data[0];
            end
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                sb.note_quat(i_s_axis_tdata, deg_mode);
            end
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                sb.check_angles(o_m_axis_tdata, o_m_axis_tuser[0]);
            end
        end
    end

    // Receiver: stall at random for sink_pct cycles of a hundred.
    always @(posedge i_clk) begin
        i_m_axis_tready <= !($urandom_range(0, 99) < sink_pct);
    end

    // Watchdog: count cycles with no transfer on any channel.
    always @(posedge i_clk) begin
        if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready)
                || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= DOG_LIMIT) begin
            $display("** quaternion_to_euler: FAILED **");
            $finish;
        end
    end

    // Hold the item until the transfer happens; insert random gaps first.
    task automatic send_quat(input logic [15:0] qr, qi, qj, qk);
        while ($urandom_range(0, 99) < send_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {qk, qj, qi, qr};
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
    endtask

    // Drain the pipeline, then write the mode register.
    task automatic write_mode(input bit deg);
        i_s_axis_tvalid <= 1'b0;
        while (sb.pending_angles.size() != 0) @(posedge i_clk);
        repeat (LAT_WAIT) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= deg;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [15:0] pick_edge_value();
        case ($urandom_range(0, 5))
            0: return 16'h0000;
            1: return 16'h0001;
            2: return 16'hFFFF;
            3: return 16'h8000;
            4: return 16'h7FFF;
            default: return 16'h4000;
        endcase
    endfunction

    task automatic send_random_quat();
        logic [15:0] a, b, c;
        logic        flip;
        a    = 16'($urandom_range(0, 32767) - 16384);
        b    = 16'($urandom_range(0, 32767) - 16384);
        c    = 16'($urandom);
        flip = 1'($urandom_range(0, 1));
        case ($urandom_range(0, 9))
            0, 1, 2: send_quat(16'($urandom), 16'($urandom), 16'($urandom),
                               16'($urandom));
            // quaternions with every component in [-1, 1) in Q2.14
            3, 4:    send_quat(a, b, 16'($urandom_range(0, 32767) - 16384),
                               16'($urandom_range(0, 32767) - 16384));
            // gimbal lock: asin argument at exactly plus or minus one
            5:       send_quat(a, b, flip ? -a : a, flip ? b : -b);
            // near gimbal lock, argument at or just inside one
            6:       send_quat(a, b, 16'(a + $urandom_range(0, 3)), -b);
            7:       send_quat(pick_edge_value(), pick_edge_value(),
                               pick_edge_value(), pick_edge_value());
            // one random component, rest tiny
            8:       send_quat(c, 16'($urandom_range(0, 7)), 16'hFFFF,
                               16'($urandom_range(0, 3)));
            default: send_quat(16'h0, 16'h0, 16'h0, 16'h0);
        endcase
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed set in degrees mode (reset value).
        send_quat(16'h4000, 16'h0000, 16'h0000, 16'h0000);  // identity
        send_quat(16'h0000, 16'h0000, 16'h0000, 16'h0000);  // zero norm
        send_quat(16'h8000, 16'h8000, 16'h8000, 16'h8000);  // most negative
        send_quat(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);  // most positive
        send_quat(16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000);
        send_quat(16'h2D41, 16'h0000, 16'h2D41, 16'h0000);  // pitch +90
        send_quat(16'h2D41, 16'h0000, 16'hD2BF, 16'h0000);  // pitch -90
        send_quat(16'h2000, 16'h2000, 16'h2000, 16'hE000);  // saturated asin
        send_quat(16'h0000, 16'h4000, 16'h0000, 16'h0000);  // roll at pi
        send_quat(16'h0000, 16'h0000, 16'h0000, 16'h4000);
        send_quat(16'h0000, 16'h0000, 16'h4000, 16'h0000);
        send_quat(16'h0001, 16'h0000, 16'h0000, 16'h0000);  // tiny norm
        send_quat(16'h0000, 16'h0001, 16'h0001, 16'h0000);
        send_quat(16'hC000, 16'h0000, 16'h0000, 16'hFFFF);  // negative real part, tiny k
        send_quat(16'h7FFF, 16'h0000, 16'h0000, 16'h0000);  // large norm

        // Four idling phases, alternating modes: none, sender, receiver, both.
        for (int ph = 0; ph < 4; ph++) begin
            write_mode(ph[0]);
            case (ph)
                1: begin
                    send_pct = 52;
                    sink_pct = 0;
                end
                2: begin
                    send_pct = 0;
                    sink_pct = 52;
                end
                3: begin
                    send_pct = 8;
                    sink_pct = 8;
                end
                default: begin
                    send_pct = 0;
                    sink_pct = 0;
                end
            endcase
            for (int n = 0; n < 434; n++) begin
                send_random_quat();
            end
        end

        i_s_axis_tvalid <= 1'b0;
        send_pct = 0;
        sink_pct = 0;
        while (sb.pending_angles.size() != 0) @(posedge i_clk);
        repeat (LAT_WAIT) @(posedge i_clk);
        if (sb.mismatches == 0) begin
            $display("** quaternion_to_euler: PASSED **");
        end else begin
            $display("** quaternion_to_euler: FAILED **");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
sv/q2e_pkg.sv
sv/q2e_isqrt_cell.sv
sv/q2e_norm_cell.sv
sv/q2e_cordic_cell.sv
sv/quaternion_to_euler.sv
dv/tb_top.sv
